>>> hdl/rau_pkg.sv
// ----------------------------------------------------------------------------
// rau_pkg
// Shared types, widths and codes of the rational arithmetic unit.
// ----------------------------------------------------------------------------
package rau_pkg;

  localparam int MAG_WIDTH = 31;
  localparam int DW        = 64;
  localparam int CNT_W     = $clog2(DW);

  typedef logic [MAG_WIDTH-1:0]   mag_t;
  typedef logic [2*MAG_WIDTH-1:0] prod_t;
  typedef logic [DW-1:0]          word_t;

  localparam logic [2:0] CMD_ADD = 3'd0;
  localparam logic [2:0] CMD_SUB = 3'd1;
  localparam logic [2:0] CMD_MUL = 3'd2;
  localparam logic [2:0] CMD_DIV = 3'd3;
  localparam logic [2:0] CMD_CMP = 3'd4;

  localparam logic [1:0] CMP_LT = 2'd0;
  localparam logic [1:0] CMP_EQ = 2'd1;
  localparam logic [1:0] CMP_GT = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_ZERO_DEN = 2'd1;
  localparam logic [1:0] ST_DIV_ZERO = 2'd2;
  localparam logic [1:0] ST_OVERFLOW = 2'd3;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_t;

  typedef struct packed {
    logic carry;   // carry out on add, borrow on subtract
    logic zero;
  } alu_flags_t;

endpackage

>>> hdl/rau_req_if.sv
// ----------------------------------------------------------------------------
// rau_req_if
// Request channel: command and two signed rational operands.
// ----------------------------------------------------------------------------
interface rau_req_if
  import rau_pkg::*;
;
  logic       valid;
  logic       ready;
  logic [2:0] cmd;
  logic       a_neg;
  mag_t       a_num;
  mag_t       a_den;
  logic       b_neg;
  mag_t       b_num;
  mag_t       b_den;

  modport source (output valid, cmd, a_neg, a_num, a_den, b_neg, b_num, b_den,
                  input ready);
  modport sink   (input valid, cmd, a_neg, a_num, a_den, b_neg, b_num, b_den,
                  output ready);
endinterface

>>> hdl/rau_rsp_if.sv
// ----------------------------------------------------------------------------
// rau_rsp_if
// Response channel: reduced rational, compare outcome and status.
// ----------------------------------------------------------------------------
interface rau_rsp_if
  import rau_pkg::*;
;
  logic       valid;
  logic       ready;
  logic       res_neg;
  mag_t       res_num;
  mag_t       res_den;
  logic [1:0] cmp_result;
  logic [1:0] status;

  modport source (output valid, res_neg, res_num, res_den, cmp_result, status,
                  input ready);
  modport sink   (input valid, res_neg, res_num, res_den, cmp_result, status,
                  output ready);
endinterface

>>> hdl/rau_alu.sv
// ----------------------------------------------------------------------------
// rau_alu
// Shared adder/subtractor with carry and zero flags.
// ----------------------------------------------------------------------------
module rau_alu
  import rau_pkg::*;
(
  input  word_t      a,
  input  word_t      b,
  input  alu_op_t    op,
  output word_t      sum,
  output alu_flags_t flags
);

  logic [DW:0] full;

  always_comb begin
    if (op == ALU_SUB) begin
      full = {1'b0, a} - {1'b0, b};
    end else begin
      full = {1'b0, a} + {1'b0, b};
    end
  end

  assign sum         = full[DW-1:0];
  assign flags.carry = full[DW];
  assign flags.zero  = (full[DW-1:0] == '0);

endmodule

>>> hdl/rau_mul.sv
// ----------------------------------------------------------------------------
// rau_mul
// Magnitude multiplier with a registered product.
// ----------------------------------------------------------------------------
module rau_mul
  import rau_pkg::*;
(
  input  logic  clk,
  input  mag_t  a,
  input  mag_t  b,
  output prod_t prod
);

  always_ff @(posedge clk) begin
    prod <= prod_t'(a) * prod_t'(b);
  end

endmodule

>>> hdl/rational_arithmetic_unit_core.sv
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_core
// Signed rational add, subtract, multiply, divide and compare with reduction
// to lowest terms.
// ----------------------------------------------------------------------------
// One request at a time. Errors and unknown commands skip the datapath and answer from S_DONE.
// Otherwise three products go through one registered multiplier, the sign
// combine uses the shared adder, the binary GCD takes one adder pass or one
// single-bit shift per cycle (data dependent), and the two exact divisions
// by the GCD run one quotient bit at a time on the same adder. The result
// then waits in an output register; a new request is taken while it waits.
module rational_arithmetic_unit_core
  import rau_pkg::*;
(
  input  logic clk,
  input  logic rst,
  rau_req_if.sink   req,
  rau_rsp_if.source rsp
);

  typedef enum logic [16:0] {
    S_IDLE  = 17'b00000000000000001,
    S_MUL_P = 17'b00000000000000010,
    S_MUL_Q = 17'b00000000000000100,
    S_MUL_D = 17'b00000000000001000,
    S_COMB  = 17'b00000000000010000,
    S_ADD   = 17'b00000000000100000,
    S_RSUB  = 17'b00000000001000000,
    S_CHK   = 17'b00000000010000000,
    S_TWOS  = 17'b00000000100000000,
    S_ODD   = 17'b00000001000000000,
    S_GCD   = 17'b00000010000000000,
    S_GSUBY = 17'b00000100000000000,
    S_SCALE = 17'b00001000000000000,
    S_DIVN  = 17'b00010000000000000,
    S_DIVD  = 17'b00100000000000000,
    S_DONE  = 17'b01000000000000000,
    S_SPARE = 17'b10000000000000000
  } state_t;

  state_t state;

  logic [2:0]       cmd;
  logic             an, bn, pneg, qneg, rneg;
  mag_t             anum, aden, bnum, bden;
  word_t            p, q, nreg, dreg, x, y, rem, dq;
  logic [CNT_W-1:0] twos, cnt;

  logic       r_neg;
  mag_t       r_num, r_den;
  logic [1:0] r_cmp, r_st;

  mag_t       mul_a, mul_b;
  prod_t      prod;
  word_t      prod_w;
  word_t      alu_a, alu_b, alu_sum;
  alu_op_t    alu_op;
  alu_flags_t alu_fl;

  word_t trial, rem_next, dq_next;
  logic  qbit;
  logic  qneg_eff;
  logic  an_in, bn_in;

  rau_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  rau_alu u_alu (
    .a     (alu_a),
    .b     (alu_b),
    .op    (alu_op),
    .sum   (alu_sum),
    .flags (alu_fl)
  );

  assign prod_w = {{(DW-2*MAG_WIDTH){1'b0}}, prod};

  // multiplier operand select
  always_comb begin
    mul_a = anum;
    mul_b = bden;
    unique case (state)
      S_MUL_P: begin
        mul_a = anum;
        mul_b = (cmd == CMD_MUL) ? bnum : bden;
      end
      S_MUL_Q: begin
        mul_a = bnum;
        mul_b = aden;
      end
      S_MUL_D: begin
        mul_a = aden;
        mul_b = bden;
      end
      default: begin
        mul_a = anum;
        mul_b = bden;
      end
    endcase
  end

  // shared adder operand select
  assign trial = {rem[DW-2:0], dq[DW-1]};

  always_comb begin
    alu_a  = p;
    alu_b  = q;
    alu_op = ALU_SUB;
    unique case (state)
      S_ADD: begin
        alu_op = ALU_ADD;
      end
      S_RSUB: begin
        alu_a = q;
        alu_b = p;
      end
      S_GCD: begin
        alu_a = x;
        alu_b = y;
      end
      S_GSUBY: begin
        alu_a = y;
        alu_b = x;
      end
      S_DIVN, S_DIVD: begin
        alu_a = trial;
        alu_b = x;
      end
      default: begin
        alu_a  = p;
        alu_b  = q;
        alu_op = ALU_SUB;
      end
    endcase
  end

  assign qbit     = !alu_fl.carry;
  assign rem_next = qbit ? alu_sum : trial;
  assign dq_next  = {dq[DW-2:0], qbit};

  assign qneg_eff = (cmd == CMD_SUB) ? ((q != '0) ? !qneg : 1'b0) : qneg;
  assign an_in    = req.a_neg && (req.a_num != '0);
  assign bn_in    = req.b_neg && (req.b_num != '0);

  assign req.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            cmd  <= req.cmd;
            an   <= an_in;
            bn   <= bn_in;
            anum <= req.a_num;
            aden <= req.a_den;
            bnum <= req.b_num;
            bden <= req.b_den;
            r_neg <= 1'b0;
            r_num <= '0;
            r_den <= mag_t'(1);
            r_cmp <= CMP_LT;
            r_st  <= ST_OK;
            if (req.cmd > CMD_CMP) begin
              state <= S_DONE;
            end else if (req.a_den == '0 || req.b_den == '0) begin
              r_st  <= ST_ZERO_DEN;
              state <= S_DONE;
            end else if (req.cmd == CMD_DIV && req.b_num == '0) begin
              r_st  <= ST_DIV_ZERO;
              state <= S_DONE;
            end else begin
              state <= S_MUL_P;
            end
          end
        end
        S_MUL_P: begin
          state <= S_MUL_Q;
        end
        S_MUL_Q: begin
          p     <= prod_w;
          state <= S_MUL_D;
        end
        S_MUL_D: begin
          q     <= prod_w;
          pneg  <= an;
          qneg  <= bn;
          state <= S_COMB;
        end
        S_COMB: begin
          dreg <= (cmd == CMD_DIV) ? q : prod_w;
          if (cmd == CMD_MUL || cmd == CMD_DIV) begin
            nreg  <= p;
            rneg  <= an ^ bn;
            state <= S_CHK;
          end else if (cmd == CMD_CMP) begin
            if (pneg != qneg) begin
              r_cmp <= pneg ? CMP_LT : CMP_GT;
            end else if (alu_fl.zero) begin
              r_cmp <= CMP_EQ;
            end else if (qbit != pneg) begin
              r_cmp <= CMP_GT;
            end else begin
              r_cmp <= CMP_LT;
            end
            state <= S_DONE;
          end else begin
            qneg <= qneg_eff;
            if (pneg == qneg_eff) begin
              state <= S_ADD;
            end else if (qbit) begin
              nreg  <= alu_sum;
              rneg  <= pneg;
              state <= S_CHK;
            end else begin
              state <= S_RSUB;
            end
          end
        end
        S_ADD: begin
          nreg  <= alu_sum;
          rneg  <= pneg;
          state <= S_CHK;
        end
        S_RSUB: begin
          nreg  <= alu_sum;
          rneg  <= qneg;
          state <= S_CHK;
        end
        S_CHK: begin
          if (nreg == '0) begin
            state <= S_DONE;
          end else begin
            x     <= nreg;
            y     <= dreg;
            twos  <= '0;
            state <= S_TWOS;
          end
        end
        S_TWOS: begin
          // strip common factors of two
          if (!(x[0] | y[0])) begin
            x    <= x >> 1;
            y    <= y >> 1;
            twos <= twos + 1'b1;
          end else begin
            state <= S_ODD;
          end
        end
        S_ODD: begin
          if (x[0] && y[0]) begin
            state <= S_GCD;
          end else begin
            if (!x[0]) x <= x >> 1;
            if (!y[0]) y <= y >> 1;
          end
        end
        S_GCD: begin
          if (alu_fl.zero) begin
            state <= S_SCALE;
          end else if (qbit) begin
            x     <= alu_sum >> 1;
            state <= S_ODD;
          end else begin
            state <= S_GSUBY;
          end
        end
        S_GSUBY: begin
          y     <= alu_sum >> 1;
          state <= S_ODD;
        end
        S_SCALE: begin
          // x holds the odd part of the gcd; remove the power of two by shifting
          dreg  <= dreg >> twos;
          dq    <= nreg >> twos;
          rem   <= '0;
          cnt   <= '0;
          state <= S_DIVN;
        end
        S_DIVN: begin
          cnt <= cnt + 1'b1;
          if (cnt == '1) begin
            nreg  <= dq_next;
            dq    <= dreg;
            rem   <= '0;
            state <= S_DIVD;
          end else begin
            dq  <= dq_next;
            rem <= rem_next;
          end
        end
        S_DIVD: begin
          cnt <= cnt + 1'b1;
          if (cnt == '1) begin
            if (nreg[DW-1:MAG_WIDTH] != '0 || dq_next[DW-1:MAG_WIDTH] != '0) begin
              r_st <= ST_OVERFLOW;
            end else begin
              r_neg <= rneg;
              r_num <= nreg[MAG_WIDTH-1:0];
              r_den <= dq_next[MAG_WIDTH-1:0];
            end
            state <= S_DONE;
          end else begin
            dq  <= dq_next;
            rem <= rem_next;
          end
        end
        S_DONE: begin
          if (!rsp.valid || rsp.ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (state == S_DONE && (!rsp.valid || rsp.ready)) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && (!rsp.valid || rsp.ready)) begin
      rsp.res_neg    <= r_neg;
      rsp.res_num    <= r_num;
      rsp.res_den    <= r_den;
      rsp.cmp_result <= r_cmp;
      rsp.status     <= r_st;
    end
  end

endmodule

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the rational arithmetic unit. A driver feeds
// requests from a queue and predicts each reduced result when its beat is
// taken. A monitor compares every response, field by field, with the oldest
// prediction. Both channels idle at random, and the response side holds off
// for one long stretch.
// ----------------------------------------------------------------------------
module tb_top;
  import rau_pkg::*;

  localparam int N_RANDOM = 1230;
  localparam int LIMIT    = 5000000;
  localparam int DRAIN    = 600;
  localparam logic [63:0] MAG_MAX = (64'd1 << MAG_WIDTH) - 64'd1;

  typedef struct {
    logic [2:0] cmd;
    logic       a_neg;
    mag_t       a_num;
    mag_t       a_den;
    logic       b_neg;
    mag_t       b_num;
    mag_t       b_den;
  } rat_req_t;

  typedef struct packed {
    logic       neg;
    mag_t       num;
    mag_t       den;
    logic [1:0] cmp;
    logic [1:0] st;
  } rat_rsp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  rau_req_if req ();
  rau_rsp_if rsp ();

  rational_arithmetic_unit_core dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  always #5 clk = ~clk;

  rat_req_t pending_ops[$];
  rat_rsp_t expected_results[$];
  int       n_total = 0;
  int       n_taken = 0;
  int       n_checked = 0;
  int       n_errors = 0;
  int       st_seen[4];
  int       cmd_seen[8];
  int       cycles = 0;

  // Reduce a signed rational result to lowest terms (binary GCD).
  function automatic rat_rsp_t reduce_rational(rat_req_t r);
    logic [63:0] an, ad, bn, bd, pm, qm, num, den, x, y, d;
    logic        sa, sb, pn, qn, rn;
    int          twos;
    rat_rsp_t    o;
    o  = '{neg: 1'b0, num: '0, den: mag_t'(1), cmp: CMP_LT, st: ST_OK};
    an = 64'(r.a_num);
    ad = 64'(r.a_den);
    bn = 64'(r.b_num);
    bd = 64'(r.b_den);
    sa = r.a_neg && (an != 0);
    sb = r.b_neg && (bn != 0);
    if (r.cmd > CMD_CMP) return o;
    if (ad == 0 || bd == 0) begin
      o.st = ST_ZERO_DEN;
      return o;
    end
    case (r.cmd)
      CMD_MUL: begin
        num = an * bn;
        den = ad * bd;
        rn  = sa ^ sb;
      end
      CMD_DIV: begin
        if (bn == 0) begin
          o.st = ST_DIV_ZERO;
          return o;
        end
        num = an * bd;
        den = ad * bn;
        rn  = sa ^ sb;
      end
      default: begin
        pm = an * bd;
        qm = bn * ad;
        pn = sa;
        qn = sb;
        if (r.cmd == CMD_CMP) begin
          if (pn != qn)          o.cmp = pn ? CMP_LT : CMP_GT;
          else if (pm == qm)     o.cmp = CMP_EQ;
          else if ((pm > qm) != pn) o.cmp = CMP_GT;
          else                   o.cmp = CMP_LT;
          return o;
        end
        if (r.cmd == CMD_SUB) qn = (qm != 0) ? !qn : 1'b0;
        if (pn == qn) begin
          num = pm + qm;
          rn  = pn;
        end else if (pm >= qm) begin
          num = pm - qm;
          rn  = pn;
        end else begin
          num = qm - pm;
          rn  = qn;
        end
        den = ad * bd;
      end
    endcase
    if (num == 0) return o;
    x = num;
    y = den;
    twos = 0;
    while (((x | y) & 64'd1) == 0) begin
      x = x >> 1;
      y = y >> 1;
      twos++;
    end
    while (x[0] == 1'b0) x = x >> 1;
    while (y[0] == 1'b0) y = y >> 1;
    while (x != y) begin
      d = (x > y) ? x - y : y - x;
      while (d[0] == 1'b0) d = d >> 1;
      if (x > y) x = d;
      else       y = d;
    end
    x   = x << twos;
    num = num / x;
    den = den / x;
    if (num > MAG_MAX || den > MAG_MAX) begin
      o.st = ST_OVERFLOW;
      return o;
    end
    o.neg = rn;
    o.num = mag_t'(num);
    o.den = mag_t'(den);
    return o;
  endfunction

  task automatic add_op(logic [2:0] c, logic an, mag_t anum, mag_t aden,
                        logic bn, mag_t bnum, mag_t bden);
    rat_req_t r;
    r = '{c, an, anum, aden, bn, bnum, bden};
    pending_ops.push_back(r);
    n_total++;
  endtask

  // Mostly small magnitudes so results stay in range; some full width.
  function automatic mag_t rand_mag();
    int k;
    k = $urandom_range(0, 19);
    if (k == 0)  return '0;
    if (k < 11)  return mag_t'($urandom_range(1, 255));
    if (k < 15)  return mag_t'($urandom_range(1, 65535));
    if (k < 17)  return mag_t'($urandom_range(1, 2000000));
    if (k == 17) return mag_t'('1) - mag_t'($urandom_range(0, 15));
    return mag_t'($urandom);
  endfunction

  function automatic mag_t rand_den();
    mag_t v;
    v = rand_mag();
    if ($urandom_range(0, 39) == 0) return '0;
    return (v == 0) ? mag_t'(1) : v;
  endfunction

  function automatic logic [2:0] rand_cmd();
    if ($urandom_range(0, 29) == 0) return 3'($urandom_range(5, 7));
    return 3'($urandom_range(0, 4));
  endfunction

  function automatic int idle_pct(bit sender);
    if (n_taken < 420) return sender ? 34 : 60;
    if (n_taken < 840) return sender ? 60 : 34;
    return 0;
  endfunction

  // Driver: present the next request, predict on the accepted beat.
  always @(posedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
    end else begin
      if (req.valid && req.ready) begin
        rat_req_t r;
        r = '{req.cmd, req.a_neg, req.a_num, req.a_den,
              req.b_neg, req.b_num, req.b_den};
        expected_results.push_back(reduce_rational(r));
        cmd_seen[r.cmd]++;
        n_taken++;
      end
      if (!req.valid || req.ready) begin
        if (pending_ops.size() != 0 && $urandom_range(0, 99) >= idle_pct(1'b1)) begin
          rat_req_t r;
          r = pending_ops.pop_front();
          req.valid <= 1'b1;
          req.cmd   <= r.cmd;
          req.a_neg <= r.a_neg;
          req.a_num <= r.a_num;
          req.a_den <= r.a_den;
          req.b_neg <= r.b_neg;
          req.b_num <= r.b_num;
          req.b_den <= r.b_den;
        end else begin
          req.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each response beat and drive ready.
  int  hold_left = 0;
  bit  hold_done = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        rat_rsp_t got;
        rat_rsp_t want;
        got = '{rsp.res_neg, rsp.res_num, rsp.res_den, rsp.cmp_result, rsp.status};
        if (expected_results.size() == 0) begin
          $display("%0t: response with nothing pending: neg=%0d num=%0d den=%0d cmp=%0d st=%0d",
                   $time, got.neg, got.num, got.den, got.cmp, got.st);
          n_errors++;
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch exp neg=%0d num=%0d den=%0d cmp=%0d st=%0d",
                     $time, want.neg, want.num, want.den, want.cmp, want.st);
            $display("%0t:          got neg=%0d num=%0d den=%0d cmp=%0d st=%0d",
                     $time, got.neg, got.num, got.den, got.cmp, got.st);
            n_errors++;
          end
          st_seen[want.st]++;
        end
        n_checked++;
      end
      // long hold-off once: the unit fills and stalls the request side
      if (!hold_done && n_taken >= 900) begin
        hold_done <= 1'b1;
        hold_left <= 400;
        rsp.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= ($urandom_range(0, 99) >= idle_pct(1'b0));
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    localparam mag_t MX = '1;
    req.valid = 1'b0;
    req.cmd   = CMD_ADD;
    req.a_neg = 1'b0;
    req.a_num = '0;
    req.a_den = mag_t'(1);
    req.b_neg = 1'b0;
    req.b_num = '0;
    req.b_den = mag_t'(1);
    rsp.ready = 1'b0;

    add_op(CMD_ADD, 0, 1, 2, 0, 1, 3);
    add_op(CMD_SUB, 1, 3, 4, 1, 5, 6);
    add_op(CMD_MUL, 1, 2, 3, 0, 9, 4);
    add_op(CMD_DIV, 0, 7, 5, 1, 14, 15);
    add_op(CMD_CMP, 1, 1, 2, 0, 1, 3);
    add_op(CMD_CMP, 0, 2, 4, 0, 1, 2);
    add_op(CMD_CMP, 1, 1, 2, 1, 2, 3);
    add_op(CMD_ADD, MX[0], MX, 1, 0, MX, 1);
    add_op(CMD_MUL, 0, MX, 1, 1, MX, 1);
    add_op(CMD_MUL, 1, MX, MX, 1, MX, MX);
    add_op(CMD_SUB, 0, 1, MX, 0, 1, MX);
    add_op(CMD_ADD, 1, 0, 5, 1, 0, 7);
    add_op(CMD_CMP, 1, 0, 3, 0, 0, 9);
    add_op(CMD_ADD, 0, 1, 0, 0, 1, 1);
    add_op(CMD_MUL, 0, 1, 1, 0, 1, 0);
    add_op(CMD_DIV, 0, 3, 4, 1, 0, 5);
    add_op(CMD_DIV, 0, 3, 0, 0, 0, 5);
    add_op(CMD_DIV, 0, 1 << 30, 3, 0, 1 << 30, 3);
    add_op(CMD_MUL, 0, 1 << 30, 3, 0, 3, 1 << 30);
    add_op(3'd5, 1, 7, 0, 1, 3, 2);
    add_op(3'd7, 0, MX, MX, 0, MX, MX);
    add_op(CMD_DIV, 0, 1, MX, 0, MX, 1);
    for (int i = 0; i < N_RANDOM; i++)
      add_op(rand_cmd(), 1'($urandom), rand_mag(), rand_den(),
             1'($urandom), rand_mag(), rand_den());

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    while (n_taken < n_total || expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    $display("Checked %0d responses: add %0d sub %0d mul %0d div %0d cmp %0d other %0d",
             n_checked, cmd_seen[0], cmd_seen[1], cmd_seen[2], cmd_seen[3], cmd_seen[4],
             cmd_seen[5] + cmd_seen[6] + cmd_seen[7]);
    $display("Status ok %0d, zero denominator %0d, divide by zero %0d, overflow %0d",
             st_seen[0], st_seen[1], st_seen[2], st_seen[3]);
    if (n_errors == 0 && n_checked == n_total)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
